/* rtl/srctl_pkg.sv */
// Shared types and constants of the stepper ramp controller.
// Holds the channel payload structs, command and result codes and the sequencer states.
// No dependencies; the interfaces and the top level use it.
`default_nettype none

package srctl_pkg;

    // Command codes of the input item.
    localparam logic [2:0] CMD_MOVE   = 3'd0;
    localparam logic [2:0] CMD_STOP   = 3'd1;
    localparam logic [2:0] CMD_UPDATE = 3'd2;
    localparam logic [2:0] CMD_DIAG   = 3'd3;
    localparam logic [2:0] CMD_ENABLE = 3'd4;

    // Move outcome codes.
    localparam logic [1:0] RES_NONE    = 2'd0;
    localparam logic [1:0] RES_DONE    = 2'd1;
    localparam logic [1:0] RES_STOPPED = 2'd2;
    localparam logic [1:0] RES_STALLED = 2'd3;

    // Stall check modes; the remaining codes perform no check.
    localparam logic [1:0] STALL_SENSED  = 2'd1;
    localparam logic [1:0] STALL_LATCHED = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_START_SPEED  = 3'd0;
    localparam logic [2:0] CFG_TARGET_SPEED = 3'd1;
    localparam logic [2:0] CFG_ACCELERATION = 3'd2;
    localparam logic [2:0] CFG_STALL_MODE   = 3'd3;

    // Configuration reset values.
    localparam logic [15:0] RST_START_SPEED  = 16'd500;
    localparam logic [15:0] RST_TARGET_SPEED = 16'd2000;
    localparam logic [23:0] RST_ACCELERATION = 24'd4000;
    localparam logic [1:0]  RST_STALL_MODE   = 2'd0;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] step_count;
        logic               stop_on_stall;
        logic               enable_level;
        logic               finished_step;
        logic               stall_sensed;
    } t_in_item;

    typedef struct packed {
        logic        accepted;
        logic        busy_res;
        logic        direction;
        logic        driver_enabled;
        logic [23:0] step_rate;
        logic [30:0] steps_left;
        logic [1:0]  move_result;
    } t_out_item;

    typedef struct packed {
        logic [2:0]  index;
        logic [23:0] wdata;
    } t_cfg_wr;

    // Ramp sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ_CUR,
        ST_SQ_START,
        ST_SQ_TGT,
        ST_BRAKE_MUL,
        ST_DECIDE,
        ST_ROOT
    } t_state;

    // Operand pairs of the shared multiplier.
    typedef enum logic [1:0] {
        MUL_CUR,
        MUL_START,
        MUL_TGT,
        MUL_BRAKE
    } t_mul_sel;

endpackage

`default_nettype wire

/* rtl/srctl_if.sv */
// Valid/ready channel interfaces of the stepper ramp controller.
// Input command, result and configuration write channels; payload types come from srctl_pkg.
`default_nettype none

interface srctl_in_if;
    logic                 valid;
    logic                 ready;
    srctl_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface srctl_out_if;
    logic                 valid;
    logic                 ready;
    srctl_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface srctl_cfg_if;
    logic                 valid;
    logic                 ready;
    srctl_pkg::t_cfg_wr   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/srctl_mul.sv */
// Shared registered multiplier of the ramp datapath.
// Unsigned product, registered once; standalone, no package use.
`default_nettype none

module srctl_mul #(
    parameter int A_BITS = 31,
    parameter int B_BITS = 24
) (
    input  wire logic                     i_clk,
    input  wire logic [A_BITS-1:0]        i_a,
    input  wire logic [B_BITS-1:0]        i_b,
    output logic      [A_BITS+B_BITS-1:0] o_p
);

    logic [A_BITS+B_BITS-1:0] r_p;
    logic [A_BITS+B_BITS-1:0] n_p;

    // Full-width product of the selected operands.
    always_comb begin
        n_p = (A_BITS + B_BITS)'(i_a) * (A_BITS + B_BITS)'(i_b);
    end

    // The product is registered before anything uses it.
    always_ff @(posedge i_clk) begin
        r_p <= n_p;
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

/* rtl/srctl_isqrt.sv */
// Iterative integer square root, one result bit per cycle.
// Restoring digit-by-digit method over a 2*ROOT_BITS-bit radicand; no package use.
`default_nettype none

module srctl_isqrt #(
    parameter int ROOT_BITS = 24
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic [2*ROOT_BITS-1:0] i_value,
    output logic                        o_done,
    output logic      [ROOT_BITS-1:0]   o_root
);

    localparam int VB = 2 * ROOT_BITS;
    localparam int CB = $clog2(ROOT_BITS + 1);

    logic                 r_busy;
    logic                 n_busy;
    logic                 r_done;
    logic                 n_done;
    logic [CB-1:0]        r_count;
    logic [CB-1:0]        n_count;
    logic [VB-1:0]        r_val;
    logic [VB-1:0]        n_val;
    logic [ROOT_BITS+1:0] r_rem;
    logic [ROOT_BITS+1:0] n_rem;
    logic [ROOT_BITS-1:0] r_root;
    logic [ROOT_BITS-1:0] n_root;

    logic [ROOT_BITS+1:0] rem_sh;
    logic [ROOT_BITS+1:0] trial;
    logic                 fits;

    // One step: bring down two radicand bits and try a one digit.
    // The partial remainder stays below 2^ROOT_BITS before the last step,
    // so its top two bits can be dropped in the shift.
    assign rem_sh = {r_rem[ROOT_BITS-1:0], r_val[VB-1 -: 2]};
    assign trial  = {r_root, 2'b01};
    assign fits   = (rem_sh >= trial);

    // Next values of the iteration registers.
    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_count = r_count;
        n_val   = r_val;
        n_rem   = r_rem;
        n_root  = r_root;
        if (i_start) begin
            n_busy  = 1'b1;
            n_count = CB'(ROOT_BITS);
            n_val   = i_value;
            n_rem   = '0;
            n_root  = '0;
        end else if (r_busy) begin
            n_val   = r_val << 2;
            n_rem   = fits ? (rem_sh - trial) : rem_sh;
            n_root  = {r_root[ROOT_BITS-2:0], fits};
            n_count = r_count - 1'b1;
            if (r_count == CB'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_busy  <= n_busy;
            r_done  <= n_done;
            r_count <= n_count;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_val  <= n_val;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

`default_nettype wire

/* rtl/stepper_ramp_controller_top.sv */
// Stepper ramp controller: single-axis move control with a speed-squared trapezoidal ramp.
// Move, stop, diag and enable commands, and updates without a ramp step, give a registered
// result for the transfer. A ramp update runs SQ_CUR, SQ_START, SQ_TGT and BRAKE_MUL (four
// multiplier passes) and DECIDE; with a new rate it then waits in ROOT until the square
// root unit has formed the rate bit by bit. Throughput: one command at a time; input is ready
// again in the cycle the result leaves. Reset is synchronous: defaults.
`default_nettype none

module stepper_ramp_controller_top #(
    parameter int COUNT_BITS     = 32,
    parameter int RATE_FRAC_BITS = 8
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    srctl_in_if.sink      i_in,
    srctl_out_if.source   o_out,
    srctl_cfg_if.sink     i_cfg
);

    import srctl_pkg::*;

    localparam int R  = 16 + RATE_FRAC_BITS;
    localparam int SQ = 2 * R;
    localparam int AW = (COUNT_BITS - 1 > R) ? COUNT_BITS - 1 : R;
    localparam int BW = (R > 24) ? R : 24;
    localparam int PW = AW + BW;
    localparam int SH = 2 * RATE_FRAC_BITS + 1;
    localparam int CW = PW + SH;

    // Sequencer and output handshake.
    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   r_acc;
    logic   n_acc;

    // Move state.
    logic                  r_busy;
    logic                  n_busy;
    logic [COUNT_BITS-2:0] r_rem;
    logic [COUNT_BITS-2:0] n_rem;
    logic                  r_dir;
    logic                  n_dir;
    logic                  r_stall_stop;
    logic                  n_stall_stop;
    logic                  r_stall_latch;
    logic                  n_stall_latch;
    logic [1:0]            r_last;
    logic [1:0]            n_last;
    logic [R-1:0]          r_rate;
    logic [R-1:0]          n_rate;
    logic                  r_en;
    logic                  n_en;

    // Configuration registers.
    logic [15:0] r_start;
    logic [15:0] r_target;
    logic [23:0] r_accel;
    logic [1:0]  r_mode;

    // Squared rates captured from the multiplier.
    logic [SQ-1:0] r_cur2;
    logic [SQ-1:0] n_cur2;
    logic [SQ-1:0] r_s2;
    logic [SQ-1:0] n_s2;
    logic [SQ-1:0] r_t2;
    logic [SQ-1:0] n_t2;

    // Command decode.
    logic                  in_xfer;
    logic                  in_ready;
    logic [2:0]            cmd;
    logic [COUNT_BITS-1:0] raw;
    logic                  raw_neg;
    logic [COUNT_BITS-1:0] mag_full;
    logic [COUNT_BITS-2:0] mag;
    logic                  stall_now;
    logic [COUNT_BITS-2:0] rem_dec;
    logic                  ramp_go;

    // Ramp arithmetic.
    logic [R-1:0]  vs;
    logic [R-1:0]  vt;
    logic [SQ-1:0] k_val;
    logic [SQ-1:0] cur_minus_k;
    logic [SQ:0]   sum_ck;
    logic [CW-1:0] brake_lhs;
    logic [CW-1:0] brake_rhs;
    logic          brake;
    logic          use_root;
    logic [SQ-1:0] root_in;

    // Shared units.
    t_mul_sel      mul_sel;
    logic [AW-1:0] mul_a;
    logic [BW-1:0] mul_b;
    logic [PW-1:0] mul_p;
    logic          sq_start;
    logic          sq_done;
    logic [R-1:0]  sq_root;

    // Handshake terms.
    assign in_xfer     = i_in.valid && in_ready;
    assign i_in.ready  = in_ready;
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_valid;

    // Move count: low COUNT_BITS bits, magnitude saturated for the most negative value.
    assign cmd      = i_in.data.command;
    assign raw      = i_in.data.step_count[COUNT_BITS-1:0];
    assign raw_neg  = raw[COUNT_BITS-1];
    assign mag_full = raw_neg ? (~raw + 1'b1) : raw;
    assign mag      = mag_full[COUNT_BITS-1] ? {(COUNT_BITS-1){1'b1}}
                                             : mag_full[COUNT_BITS-2:0];
    assign rem_dec  = (r_rem != '0) ? (r_rem - 1'b1) : r_rem;

    // Stall indication for the configured mode.
    always_comb begin
        case (r_mode)
            STALL_SENSED:  stall_now = i_in.data.stall_sensed;
            STALL_LATCHED: stall_now = r_stall_latch;
            default:       stall_now = 1'b0;
        endcase
    end

    // A finished step with steps left and nonzero acceleration past the stall check runs the ramp.
    assign ramp_go = (cmd == CMD_UPDATE) && r_busy && !(r_stall_stop && stall_now)
                     && i_in.data.finished_step && (rem_dec != '0) && (r_accel != '0);

    // Rates and the speed-squared step 2*a, all in Q format.
    assign vs    = R'(r_start) << RATE_FRAC_BITS;
    assign vt    = R'(r_target) << RATE_FRAC_BITS;
    assign k_val = SQ'(r_accel) << SH;

    // Brake when the remaining steps fit in the braking distance:
    // remaining * 2a * 2^(2F) <= cur^2 - start^2, with no braking at or below start.
    assign brake_lhs = CW'(r_cur2 - r_s2);
    assign brake_rhs = CW'(mul_p) << SH;
    assign brake     = (r_cur2 > r_s2) && (brake_lhs >= brake_rhs);

    // Radicand for the new rate.
    assign cur_minus_k = r_cur2 - k_val;
    assign sum_ck      = (SQ + 1)'(r_cur2) + (SQ + 1)'(k_val);
    always_comb begin
        if (brake) begin
            root_in  = ((r_cur2 > k_val) && (cur_minus_k > r_s2)) ? cur_minus_k : r_s2;
            use_root = 1'b1;
        end else if (r_rate < vt) begin
            root_in  = (sum_ck < (SQ + 1)'(r_t2)) ? sum_ck[SQ-1:0] : r_t2;
            use_root = 1'b1;
        end else begin
            root_in  = r_t2;
            use_root = 1'b0;
        end
    end

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:      if (in_xfer && ramp_go) begin
                n_state = ST_SQ_CUR;
            end
            ST_SQ_CUR:    n_state = ST_SQ_START;
            ST_SQ_START:  n_state = ST_SQ_TGT;
            ST_SQ_TGT:    n_state = ST_BRAKE_MUL;
            ST_BRAKE_MUL: n_state = ST_DECIDE;
            ST_DECIDE:    n_state = use_root ? ST_ROOT : ST_IDLE;
            ST_ROOT:      if (sq_done) begin
                n_state = ST_IDLE;
            end
            default:      n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs: input ready, multiplier operand choice, root start.
    always_comb begin
        in_ready = (r_state == ST_IDLE) && (!r_out_valid || o_out.ready);
        sq_start = (r_state == ST_DECIDE) && use_root;
        case (r_state)
            ST_SQ_CUR:   mul_sel = MUL_CUR;
            ST_SQ_START: mul_sel = MUL_START;
            ST_SQ_TGT:   mul_sel = MUL_TGT;
            default:     mul_sel = MUL_BRAKE;
        endcase
    end

    // Multiplier operand select.
    always_comb begin
        case (mul_sel)
            MUL_CUR: begin
                mul_a = AW'(r_rate);
                mul_b = BW'(r_rate);
            end
            MUL_START: begin
                mul_a = AW'(vs);
                mul_b = BW'(vs);
            end
            MUL_TGT: begin
                mul_a = AW'(vt);
                mul_b = BW'(vt);
            end
            default: begin
                mul_a = AW'(r_rem);
                mul_b = BW'(r_accel);
            end
        endcase
    end

    srctl_mul #(
        .A_BITS (AW),
        .B_BITS (BW)
    ) u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    srctl_isqrt #(
        .ROOT_BITS (R)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_value (root_in),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    // Command execution and ramp results.
    always_comb begin
        n_out_valid   = r_out_valid && !o_out.ready;
        n_acc         = r_acc;
        n_busy        = r_busy;
        n_rem         = r_rem;
        n_dir         = r_dir;
        n_stall_stop  = r_stall_stop;
        n_stall_latch = r_stall_latch;
        n_last        = r_last;
        n_rate        = r_rate;
        n_en          = r_en;
        n_cur2        = r_cur2;
        n_s2          = r_s2;
        n_t2          = r_t2;
        case (r_state)
            ST_IDLE: if (in_xfer) begin
                n_acc       = 1'b0;
                n_out_valid = 1'b1;
                case (cmd)
                    CMD_MOVE: if (!r_busy && (raw != '0)) begin
                        n_en          = 1'b1;
                        n_dir         = !raw_neg;
                        n_rem         = mag;
                        n_stall_stop  = i_in.data.stop_on_stall;
                        n_stall_latch = 1'b0;
                        n_last        = RES_NONE;
                        n_rate        = vs;
                        n_busy        = 1'b1;
                        n_acc         = 1'b1;
                    end
                    CMD_STOP: if (r_busy) begin
                        n_busy        = 1'b0;
                        n_rem         = '0;
                        n_stall_latch = 1'b0;
                        n_stall_stop  = 1'b0;
                        n_last        = RES_STOPPED;
                    end
                    CMD_UPDATE: if (r_busy) begin
                        if (r_stall_stop && stall_now) begin
                            n_busy        = 1'b0;
                            n_rem         = '0;
                            n_stall_latch = 1'b0;
                            n_stall_stop  = 1'b0;
                            n_last        = RES_STALLED;
                        end else if (i_in.data.finished_step) begin
                            if (rem_dec == '0) begin
                                n_busy        = 1'b0;
                                n_rem         = '0;
                                n_stall_latch = 1'b0;
                                n_stall_stop  = 1'b0;
                                n_last        = RES_DONE;
                            end else begin
                                n_rem = rem_dec;
                                if (r_accel == '0) begin
                                    n_rate = vt;
                                end else begin
                                    // The result waits for the ramp sequence.
                                    n_out_valid = 1'b0;
                                end
                            end
                        end
                    end
                    CMD_DIAG: if (r_mode == STALL_LATCHED) begin
                        n_stall_latch = 1'b1;
                    end
                    CMD_ENABLE: begin
                        if (!i_in.data.enable_level && r_busy) begin
                            n_busy        = 1'b0;
                            n_rem         = '0;
                            n_stall_latch = 1'b0;
                            n_stall_stop  = 1'b0;
                            n_last        = RES_STOPPED;
                        end
                        n_en = i_in.data.enable_level;
                    end
                    default: ;
                endcase
            end
            ST_SQ_START:  n_cur2 = SQ'(mul_p);
            ST_SQ_TGT:    n_s2   = SQ'(mul_p);
            ST_BRAKE_MUL: n_t2   = SQ'(mul_p);
            ST_DECIDE: if (!use_root) begin
                n_rate      = vt;
                n_out_valid = 1'b1;
            end
            ST_ROOT: if (sq_done) begin
                n_rate      = sq_root;
                n_out_valid = 1'b1;
            end
            default: ;
        endcase
    end

    // Control and move state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_out_valid   <= 1'b0;
            r_acc         <= 1'b0;
            r_busy        <= 1'b0;
            r_rem         <= '0;
            r_dir         <= 1'b0;
            r_stall_stop  <= 1'b0;
            r_stall_latch <= 1'b0;
            r_last        <= RES_NONE;
            r_rate        <= R'(RST_START_SPEED) << RATE_FRAC_BITS;
            r_en          <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_out_valid   <= n_out_valid;
            r_acc         <= n_acc;
            r_busy        <= n_busy;
            r_rem         <= n_rem;
            r_dir         <= n_dir;
            r_stall_stop  <= n_stall_stop;
            r_stall_latch <= n_stall_latch;
            r_last        <= n_last;
            r_rate        <= n_rate;
            r_en          <= n_en;
        end
    end

    // Squared-rate working registers.
    always_ff @(posedge i_clk) begin
        r_cur2 <= n_cur2;
        r_s2   <= n_s2;
        r_t2   <= n_t2;
    end

    // Configuration writes; indexes past the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start  <= RST_START_SPEED;
            r_target <= RST_TARGET_SPEED;
            r_accel  <= RST_ACCELERATION;
            r_mode   <= RST_STALL_MODE;
        end else if (i_cfg.valid) begin
            case (i_cfg.data.index)
                CFG_START_SPEED:  r_start  <= i_cfg.data.wdata[15:0];
                CFG_TARGET_SPEED: r_target <= i_cfg.data.wdata[15:0];
                CFG_ACCELERATION: r_accel  <= i_cfg.data.wdata;
                CFG_STALL_MODE:   r_mode   <= i_cfg.data.wdata[1:0];
                default: ;
            endcase
        end
    end

    // Status result, read straight from the state registers.
    assign o_out.data = '{
        accepted:       r_acc,
        busy_res:       r_busy,
        direction:      r_dir,
        driver_enabled: r_en,
        step_rate:      24'(r_rate),
        steps_left:     31'(r_rem),
        move_result:    r_last
    };

    // A move in progress always has steps left, and an idle axis has none.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy == (r_rem != '0))
        else $error("busy flag and remaining count disagree");

    // The root unit only finishes while the sequencer waits for it.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_done |-> (r_state == ST_ROOT))
        else $error("square root finished outside the root state");

    // A result appears only after a transfer or at the end of a ramp sequence.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid)) |->
            ($past(in_xfer) || $past(r_state == ST_DECIDE) || $past(r_state == ST_ROOT)))
        else $error("result raised without a source");

    // Input is never taken while the ramp sequence runs.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !in_ready)
        else $error("input ready during ramp sequence");

endmodule

`default_nettype wire
